### sv/bua_pkg.sv
`timescale 1ns / 1ps

package bua_pkg;

    typedef enum logic {
        FUNC_WRITE  = 1'b0,
        FUNC_INTERP = 1'b1
    } func_t;

    typedef logic [1:0]         plane_t;
    typedef logic [9:0]         coord_t;
    typedef logic signed [15:0] sample_t;
    typedef logic [8:0]         dim_t;
    typedef logic [23:0]        step_t;
    typedef logic [15:0]        frac_t;
    typedef logic [2:0]         cfg_index_t;
    typedef logic [23:0]        cfg_data_t;

    localparam cfg_index_t CFG_SOURCE_WIDTH  = 3'd0;
    localparam cfg_index_t CFG_SOURCE_HEIGHT = 3'd1;
    localparam cfg_index_t CFG_STEP_X        = 3'd2;
    localparam cfg_index_t CFG_STEP_Y        = 3'd3;

    localparam dim_t  SOURCE_WIDTH_RESET  = 9'd256;
    localparam dim_t  SOURCE_HEIGHT_RESET = 9'd256;
    localparam step_t STEP_RESET          = 24'd65536;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [QPTR_W-1:0] qptr_t;
    typedef logic [QCNT_W-1:0] qcnt_t;

    typedef struct packed {
        logic    is_write;
        logic    zero;
        plane_t  plane;
        dim_t    x0;
        dim_t    x1;
        dim_t    y0;
        dim_t    y1;
        frac_t   fx;
        frac_t   fy;
        sample_t sample;
    } entry_t;

endpackage

### sv/bua_cfg_if.sv
`timescale 1ns / 1ps

interface bua_cfg_if;
    logic                   valid;
    logic                   ready;
    bua_pkg::cfg_index_t    index;
    bua_pkg::cfg_data_t     data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### sv/bua_req_if.sv
`timescale 1ns / 1ps

interface bua_req_if;
    logic               valid;
    logic               ready;
    bua_pkg::func_t     func;
    bua_pkg::plane_t    plane;
    bua_pkg::coord_t    coord_x;
    bua_pkg::coord_t    coord_y;
    bua_pkg::sample_t   sample;

    modport source (output valid, output func, output plane, output coord_x,
                    output coord_y, output sample, input ready);
    modport sink (input valid, input func, input plane, input coord_x,
                  input coord_y, input sample, output ready);
endinterface

### sv/bua_rsp_if.sv
`timescale 1ns / 1ps

interface bua_rsp_if;
    logic               valid;
    logic               ready;
    bua_pkg::sample_t   value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

### sv/bilinear_upsample_align_corners.sv
`timescale 1ns / 1ps
// Path: an interpolate request passes the front register, the queue, the bank read
// (s2), s3, s4 and output registers; a write lands in the frame store when popped.
// Throughput: one item per cycle unless rsp.ready stalls, set by the four parity banks read together.
// Reset: rst_n clears control state and loads size 256x256 and steps of 1.0;
// the frame store is not cleared and holds garbage until written.
module bilinear_upsample_align_corners #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int PLANES     = 4
) (
    input  logic      clk,
    input  logic      rst_n,
    bua_cfg_if.sink   cfg,
    bua_req_if.sink   req,
    bua_rsp_if.source rsp
);

    bua_pkg::entry_t q_push_data;
    logic            q_push_valid;
    logic            q_push_ready;
    bua_pkg::entry_t q_pop_data;
    logic            q_pop_valid;
    logic            q_pop_ready;

    bua_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .PLANES     (PLANES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .req        (req),
        .push_data  (q_push_data),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready)
    );

    bua_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_data  (q_push_data),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .pop_data   (q_pop_data),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready)
    );

    bua_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .PLANES     (PLANES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_data   (q_pop_data),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .rsp        (rsp)
    );

    a_stall_holds_queue: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ready) |-> !(q_pop_valid && q_pop_ready))
        else $error("queue popped while result is stalled");

    a_push_visible: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push_valid && q_push_ready) |=> q_pop_valid)
        else $error("queue empty after transfer into it");

    a_empty_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        !q_pop_valid |-> q_push_ready)
        else $error("empty queue refuses transfer");

endmodule

### sv/bua_front.sv
`timescale 1ns / 1ps

module bua_front #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int PLANES     = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    bua_cfg_if.sink         cfg,
    bua_req_if.sink         req,
    output bua_pkg::entry_t push_data,
    output logic            push_valid,
    input  logic            push_ready
);

    typedef struct packed {
        bua_pkg::dim_t  near;
        bua_pkg::dim_t  far;
        bua_pkg::frac_t frac;
    } axis_t;

    function automatic bua_pkg::dim_t eff_size(bua_pkg::dim_t v, int maxv);
        bua_pkg::dim_t r;
        r = v;
        if (v == 9'd0)
        begin
            r = 9'd1;
        end
        else if (int'(v) > maxv)
        begin
            r = bua_pkg::dim_t'(maxv);
        end
        return r;
    endfunction

    function automatic axis_t axis_pos(logic [33:0] pos, bua_pkg::dim_t size);
        logic [33:0] lim;
        logic [33:0] pc;
        axis_t       r;
        lim    = {9'd0, size - 9'd1, 16'd0};
        pc     = (pos > lim) ? lim : pos;
        r.near = pc[24:16];
        r.frac = pc[15:0];
        r.far  = (r.near < size - 9'd1) ? r.near + 9'd1 : r.near;
        return r;
    endfunction

    bua_pkg::dim_t    width_reg;
    bua_pkg::dim_t    height_reg;
    bua_pkg::step_t   step_x_reg;
    bua_pkg::step_t   step_y_reg;

    logic             f_valid_reg;
    bua_pkg::func_t   f_func_reg;
    bua_pkg::plane_t  f_plane_reg;
    bua_pkg::coord_t  f_cx_reg;
    bua_pkg::coord_t  f_cy_reg;
    bua_pkg::sample_t f_sample_reg;
    logic [33:0]      f_pos_x_reg;
    logic [33:0]      f_pos_y_reg;

    bua_pkg::dim_t    w_eff;
    bua_pkg::dim_t    h_eff;
    logic             plane_ok;
    logic             write_ok;
    logic             ignore;
    logic             f_adv;
    axis_t            ax;
    axis_t            ay;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= bua_pkg::SOURCE_WIDTH_RESET;
            height_reg <= bua_pkg::SOURCE_HEIGHT_RESET;
            step_x_reg <= bua_pkg::STEP_RESET;
            step_y_reg <= bua_pkg::STEP_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                bua_pkg::CFG_SOURCE_WIDTH:  width_reg  <= cfg.data[8:0];
                bua_pkg::CFG_SOURCE_HEIGHT: height_reg <= cfg.data[8:0];
                bua_pkg::CFG_STEP_X:        step_x_reg <= cfg.data;
                bua_pkg::CFG_STEP_Y:        step_y_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        w_eff    = eff_size(width_reg, MAX_WIDTH);
        h_eff    = eff_size(height_reg, MAX_HEIGHT);
        plane_ok = int'(f_plane_reg) < PLANES;
        write_ok = plane_ok && (f_cx_reg < {1'b0, w_eff}) && (f_cy_reg < {1'b0, h_eff});
        ignore   = (f_func_reg == bua_pkg::FUNC_WRITE) && !write_ok;
        ax       = axis_pos(f_pos_x_reg, w_eff);
        ay       = axis_pos(f_pos_y_reg, h_eff);
    end

    assign f_adv      = f_valid_reg && (ignore || push_ready);
    assign req.ready  = !f_valid_reg || f_adv;
    assign push_valid = f_valid_reg && !ignore;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            f_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            f_func_reg   <= req.func;
            f_plane_reg  <= req.plane;
            f_cx_reg     <= req.coord_x;
            f_cy_reg     <= req.coord_y;
            f_sample_reg <= req.sample;
            f_pos_x_reg  <= 34'(step_x_reg) * 34'(req.coord_x);
            f_pos_y_reg  <= 34'(step_y_reg) * 34'(req.coord_y);
        end
    end

    always_comb
    begin
        push_data          = '0;
        push_data.sample   = f_sample_reg;
        if (f_func_reg == bua_pkg::FUNC_WRITE)
        begin
            push_data.is_write = 1'b1;
            push_data.plane    = f_plane_reg;
            push_data.x0       = f_cx_reg[8:0];
            push_data.x1       = f_cx_reg[8:0];
            push_data.y0       = f_cy_reg[8:0];
            push_data.y1       = f_cy_reg[8:0];
        end
        else if (!plane_ok)
        begin
            push_data.zero = 1'b1;
        end
        else
        begin
            push_data.plane = f_plane_reg;
            push_data.x0    = ax.near;
            push_data.x1    = ax.far;
            push_data.fx    = ax.frac;
            push_data.y0    = ay.near;
            push_data.y1    = ay.far;
            push_data.fy    = ay.frac;
        end
    end

endmodule

### sv/bua_queue.sv
`timescale 1ns / 1ps

module bua_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  bua_pkg::entry_t push_data,
    input  logic            push_valid,
    output logic            push_ready,
    output bua_pkg::entry_t pop_data,
    output logic            pop_valid,
    input  logic            pop_ready
);

    bua_pkg::entry_t store [bua_pkg::QUEUE_DEPTH];
    bua_pkg::qptr_t  wr_ptr_reg;
    bua_pkg::qptr_t  rd_ptr_reg;
    bua_pkg::qcnt_t  count_reg;
    bua_pkg::qcnt_t  count_next;
    logic            push;
    logic            pop;

    assign push_ready = count_reg != bua_pkg::QCNT_W'(bua_pkg::QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = store[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### sv/bua_back.sv
`timescale 1ns / 1ps

module bua_back #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int PLANES     = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  bua_pkg::entry_t pop_data,
    input  logic            pop_valid,
    output logic            pop_ready,
    bua_rsp_if.source       rsp
);

    localparam int PB         = (PLANES > 1) ? $clog2(PLANES) : 1;
    localparam int RHB        = (MAX_HEIGHT > 2) ? $clog2((MAX_HEIGHT + 1) / 2) : 1;
    localparam int CHB        = (MAX_WIDTH > 2) ? $clog2((MAX_WIDTH + 1) / 2) : 1;
    localparam int ADDR_W     = PB + RHB + CHB;
    localparam int BANK_DEPTH = 1 << ADDR_W;

    function automatic bua_pkg::sample_t pick(logic py, logic px,
                                              bua_pkg::sample_t q00, bua_pkg::sample_t q01,
                                              bua_pkg::sample_t q10, bua_pkg::sample_t q11);
        bua_pkg::sample_t r;
        case ({py, px})
            2'b00:   r = q00;
            2'b01:   r = q01;
            2'b10:   r = q10;
            default: r = q11;
        endcase
        return r;
    endfunction

    logic             en;
    logic             pop;
    bua_pkg::sample_t bank_q [2][2];

    logic             s2_valid_reg;
    logic             s2_zero_reg;
    logic             s2_x0p_reg;
    logic             s2_x1p_reg;
    logic             s2_y0p_reg;
    logic             s2_y1p_reg;
    bua_pkg::frac_t   s2_fx_reg;
    bua_pkg::frac_t   s2_fy_reg;

    logic             s3_valid_reg;
    logic             s3_zero_reg;
    bua_pkg::frac_t   s3_fy_reg;
    logic signed [34:0] h0_reg;
    logic signed [34:0] h1_reg;

    logic             s4_valid_reg;
    logic             s4_zero_reg;
    logic signed [52:0] acc_reg;

    logic             out_valid_reg;
    bua_pkg::sample_t out_value_reg;

    bua_pkg::sample_t s00;
    bua_pkg::sample_t s01;
    bua_pkg::sample_t s10;
    bua_pkg::sample_t s11;
    logic signed [16:0] d0;
    logic signed [16:0] d1;
    logic signed [16:0] fxs;
    logic signed [33:0] p0;
    logic signed [33:0] p1;
    logic signed [34:0] h0_next;
    logic signed [34:0] h1_next;
    logic signed [35:0] dh;
    logic signed [16:0] fys;
    logic signed [52:0] py_prod;
    logic signed [52:0] acc_next;
    logic signed [53:0] acc_rnd;
    logic signed [21:0] v_full;
    bua_pkg::sample_t value_next;

    assign en        = !out_valid_reg || rsp.ready;
    assign pop_ready = en;
    assign pop       = pop_valid && en;

    for (genvar gy = 0; gy < 2; gy++)
    begin : g_row
        for (genvar gx = 0; gx < 2; gx++)
        begin : g_col
            bua_pkg::sample_t mem [BANK_DEPTH];
            bua_pkg::sample_t rd_reg;
            bua_pkg::dim_t    row_sel;
            bua_pkg::dim_t    col_sel;
            logic [ADDR_W-1:0] addr;
            logic             we;

            assign row_sel = (pop_data.y0[0] == 1'(gy)) ? pop_data.y0 : pop_data.y1;
            assign col_sel = (pop_data.x0[0] == 1'(gx)) ? pop_data.x0 : pop_data.x1;
            assign addr    = {PB'(pop_data.plane), RHB'(row_sel >> 1), CHB'(col_sel >> 1)};
            assign we      = pop && pop_data.is_write
                             && (pop_data.y0[0] == 1'(gy)) && (pop_data.x0[0] == 1'(gx));

            always_ff @(posedge clk)
            begin
                if (we)
                begin
                    mem[addr] <= pop_data.sample;
                end
                if (en)
                begin
                    rd_reg <= mem[addr];
                end
            end

            assign bank_q[gy][gx] = rd_reg;
        end
    end

    always_comb
    begin
        s00 = pick(s2_y0p_reg, s2_x0p_reg, bank_q[0][0], bank_q[0][1],
                   bank_q[1][0], bank_q[1][1]);
        s01 = pick(s2_y0p_reg, s2_x1p_reg, bank_q[0][0], bank_q[0][1],
                   bank_q[1][0], bank_q[1][1]);
        s10 = pick(s2_y1p_reg, s2_x0p_reg, bank_q[0][0], bank_q[0][1],
                   bank_q[1][0], bank_q[1][1]);
        s11 = pick(s2_y1p_reg, s2_x1p_reg, bank_q[0][0], bank_q[0][1],
                   bank_q[1][0], bank_q[1][1]);
        fxs     = signed'({1'b0, s2_fx_reg});
        d0      = 17'(s01) - 17'(s00);
        d1      = 17'(s11) - 17'(s10);
        p0      = d0 * fxs;
        p1      = d1 * fxs;
        h0_next = (35'(s00) <<< 16) + 35'(p0);
        h1_next = (35'(s10) <<< 16) + 35'(p1);

        fys      = signed'({1'b0, s3_fy_reg});
        dh       = 36'(h1_reg) - 36'(h0_reg);
        py_prod  = dh * fys;
        acc_next = (53'(h0_reg) <<< 16) + py_prod;

        acc_rnd  = 54'(acc_reg) + 54'sd2147483648;
        v_full   = acc_rnd[53:32];
        if (v_full > 22'sd32767)
        begin
            value_next = 16'sh7fff;
        end
        else if (v_full < -22'sd32768)
        begin
            value_next = 16'sh8000;
        end
        else
        begin
            value_next = v_full[15:0];
        end
        if (s4_zero_reg)
        begin
            value_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s2_valid_reg  <= pop && !pop_data.is_write;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            out_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_zero_reg   <= pop_data.zero;
            s2_x0p_reg    <= pop_data.x0[0];
            s2_x1p_reg    <= pop_data.x1[0];
            s2_y0p_reg    <= pop_data.y0[0];
            s2_y1p_reg    <= pop_data.y1[0];
            s2_fx_reg     <= pop_data.fx;
            s2_fy_reg     <= pop_data.fy;
            s3_zero_reg   <= s2_zero_reg;
            s3_fy_reg     <= s2_fy_reg;
            h0_reg        <= h0_next;
            h1_reg        <= h1_next;
            s4_zero_reg   <= s3_zero_reg;
            acc_reg       <= acc_next;
            out_value_reg <= value_next;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.value = out_value_reg;

endmodule
